// File: hdl/interval_room_allocator_min_heap_core_defines.svh
// ----------------------------------------------------------------------------
// interval_room_allocator_min_heap_core_defines
// assertion macros used by the interval room allocator rtl
// ----------------------------------------------------------------------------
`ifndef INTERVAL_ROOM_ALLOCATOR_MIN_HEAP_CORE_DEFINES_SVH
`define INTERVAL_ROOM_ALLOCATOR_MIN_HEAP_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define IRAH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define IRAH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/irah_pkg.sv
// ----------------------------------------------------------------------------
// irah_pkg
// shared types and constants of the interval room allocator
// ----------------------------------------------------------------------------
`default_nettype none

package irah_pkg;

    localparam int TIME_W       = 31;
    localparam int ROOMS_W      = 9;
    localparam int CAPACITY_DEF = 256;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_UP,
        S_DOWN
    } t_state;

endpackage

`default_nettype wire

// File: hdl/irah_heap_mem.sv
// ----------------------------------------------------------------------------
// irah_heap_mem
// heap storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module irah_heap_mem
    import irah_pkg::*;
#(
    parameter int  DEPTH = CAPACITY_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [TIME_W-1:0] i_wdata,
    input  wire logic [AW-1:0]     i_raddr_a,
    input  wire logic [AW-1:0]     i_raddr_b,
    output logic      [TIME_W-1:0] o_rdata_a,
    output logic      [TIME_W-1:0] o_rdata_b
);

    logic [TIME_W-1:0] r_mem [DEPTH];
    logic [TIME_W-1:0] r_rd_a;
    logic [TIME_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_mem[i_raddr_a];
        r_rd_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

`default_nettype wire

// File: hdl/interval_room_allocator_min_heap_core.sv
// result strobe: registered from the check state on overflow, otherwise at the end of
//   a sift walk of at most clog2(CAPACITY) heap levels that the new end moves
// start is taken only in idle; busy stays high through the check and the sift walk
//   through the heap memory, one level per cycle on its registered read ports
// reset: synchronous active-low, empties the heap; heap memory is not cleared
// the receiver cannot stall: o_valid is a one-cycle strobe
// ----------------------------------------------------------------------------
// interval_room_allocator_min_heap_core
// min-heap of room end times; counts the rooms needed for ordered intervals
// ----------------------------------------------------------------------------
`default_nettype none
`include "interval_room_allocator_min_heap_core_defines.svh"

module interval_room_allocator_min_heap_core
    import irah_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic               i_new_set,
    input  wire logic [TIME_W-1:0]  i_start_time,
    input  wire logic [TIME_W-1:0]  i_end_time,
    output logic                    o_valid,
    output logic      [ROOMS_W-1:0] o_rooms_needed,
    output logic                    o_overflow
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = AW + 2;

    t_state            r_state;
    t_state            n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [AW-1:0]     r_pos;
    logic [AW-1:0]     n_pos;
    logic [TIME_W-1:0] r_start;
    logic [TIME_W-1:0] r_val;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_ovf;
    logic              n_ovf;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [TIME_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr_a;
    logic [AW-1:0]     mem_raddr_b;
    logic [TIME_W-1:0] rd_a;
    logic [TIME_W-1:0] rd_b;

    logic              accept;
    logic [IW-1:0]     count_ext;
    logic [IW-1:0]     l_idx;
    logic [IW-1:0]     r_idx;
    logic              l_ok;
    logic              r_ok;
    logic              do_pop;
    logic              is_full;
    logic              up_stop;
    logic              take_l;
    logic              take_r;
    logic [TIME_W-1:0] l_val;
    logic              down_stop;
    logic [AW-1:0]     best_idx;
    logic [TIME_W-1:0] best_val;
    logic [AW-1:0]     pos_parent;
    logic [AW-1:0]     ins_pos;
    logic [AW-1:0]     best_l;

    irah_heap_mem #(
        .DEPTH (CAPACITY)
    ) u_heap_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    assign accept    = start && (r_state == S_IDLE);
    assign count_ext = IW'(r_count);
    assign l_idx     = (IW'(r_pos) << 1) + IW'(1);
    assign r_idx     = l_idx + IW'(1);
    assign l_ok      = l_idx < count_ext;
    assign r_ok      = r_idx < count_ext;

    // root is on read port a during the check cycle
    assign do_pop  = (r_count != '0) && (r_start >= rd_a);
    assign is_full = r_count == CW'(CAPACITY);
    assign ins_pos = AW'(r_count);

    // sift-up: parent of the hole is on read port a
    assign pos_parent = (r_pos - AW'(1)) >> 1;
    assign up_stop    = (r_pos == '0) || (rd_a <= r_val);

    // sift-down: left child on port a, right child on port b
    assign take_l    = l_ok && (rd_a < r_val);
    assign l_val     = take_l ? rd_a : r_val;
    assign take_r    = r_ok && (rd_b < l_val);
    assign down_stop = !take_l && !take_r;
    assign best_idx  = take_r ? r_idx[AW-1:0] : l_idx[AW-1:0];
    assign best_val  = take_r ? rd_b : rd_a;
    assign best_l    = AW'({best_idx, 1'b1});

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (do_pop) begin
                    n_state = S_DOWN;
                end else if (is_full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_UP;
                end
            end
            S_UP: begin
                n_state = up_stop ? S_IDLE : S_UP;
            end
            S_DOWN: begin
                n_state = down_stop ? S_IDLE : S_DOWN;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        mem_we      = 1'b0;
        mem_waddr   = r_pos;
        mem_wdata   = r_val;
        mem_raddr_a = '0;
        mem_raddr_b = '0;
        n_pos       = r_pos;
        n_count     = r_count;
        n_out_valid = 1'b0;
        n_ovf       = r_ovf;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_new_set) begin
                    n_count = '0;
                end
            end
            S_CHECK: begin
                n_ovf = 1'b0;
                if (do_pop) begin
                    // replace the root with the new end, then sift down
                    n_pos       = '0;
                    mem_raddr_a = AW'(1);
                    mem_raddr_b = AW'(2);
                end else if (is_full) begin
                    n_ovf       = 1'b1;
                    n_out_valid = 1'b1;
                end else begin
                    n_pos       = ins_pos;
                    mem_raddr_a = (ins_pos - AW'(1)) >> 1;
                end
            end
            S_UP: begin
                mem_we = 1'b1;
                if (up_stop) begin
                    n_out_valid = 1'b1;
                    n_count     = r_count + CW'(1);
                end else begin
                    // move the parent down into the hole
                    mem_wdata   = rd_a;
                    n_pos       = pos_parent;
                    mem_raddr_a = (pos_parent - AW'(1)) >> 1;
                end
            end
            S_DOWN: begin
                mem_we = 1'b1;
                if (down_stop) begin
                    n_out_valid = 1'b1;
                end else begin
                    mem_wdata   = best_val;
                    n_pos       = best_idx;
                    mem_raddr_a = best_l;
                    mem_raddr_b = best_l + AW'(1);
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        r_ovf <= n_ovf;
        if (accept) begin
            r_start <= i_start_time;
            r_val   <= i_end_time;
        end
    end

    assign busy           = r_state != S_IDLE;
    assign o_valid        = r_out_valid;
    assign o_rooms_needed = ROOMS_W'(r_count);
    assign o_overflow     = r_ovf;

    `IRAH_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY), "heap count above capacity")
    `IRAH_ASSERT_SAME(a_ovf_full, i_clk, i_rst_n, o_valid && o_overflow, r_count == CW'(CAPACITY), "overflow reported while heap not full")
    `IRAH_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result strobe while still busy")
    `IRAH_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_valid, "accepted transaction did not start work")

endmodule

`default_nettype wire

// File: tb/interval_room_allocator_min_heap_core_checker.sv
// ----------------------------------------------------------------------------
// interval_room_allocator_min_heap_core_checker
// tracks the room heap of the allocator and checks every result strobe
// against its own prediction, in order
// ----------------------------------------------------------------------------
`default_nettype none

module interval_room_allocator_min_heap_core_checker
    import irah_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire logic               i_new_set,
    input  wire logic [TIME_W-1:0]  i_start_time,
    input  wire logic [TIME_W-1:0]  i_end_time,
    input  wire logic               i_valid,
    input  wire logic [ROOMS_W-1:0] i_rooms_needed,
    input  wire logic               i_overflow,
    output int                      o_pending,
    output int                      o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ROOMS_W-1:0] rooms;
        logic               overflow;
    } t_room_result;

    bit [TIME_W-1:0] room_ends [CAPACITY];
    int unsigned     rooms_in_use = 0;
    t_room_result    rooms_expected [$];
    int              pending_count = 0;
    int              failures = 0;

    assign o_pending  = pending_count;
    assign o_failures = failures;

    // frees the earliest ending room if this interval can reuse it, then books a room if one is free
    function automatic t_room_result predict_rooms(input bit fresh,
                                                   input bit [TIME_W-1:0] begin_at,
                                                   input bit [TIME_W-1:0] end_at);
        t_room_result    res;
        int unsigned     pos;
        int unsigned     parent;
        int unsigned     child;
        int unsigned     best;
        bit [TIME_W-1:0] tmp;

        res.overflow = 1'b0;
        if (fresh) begin
            rooms_in_use = 0;
        end
        if (rooms_in_use > 0 && begin_at >= room_ends[0]) begin
            room_ends[0] = room_ends[rooms_in_use - 1];
            rooms_in_use--;
            pos = 0;
            forever begin
                best  = pos;
                child = 2 * pos + 1;
                if (child < rooms_in_use && room_ends[child] < room_ends[best]) begin
                    best = child;
                end
                if (child + 1 < rooms_in_use && room_ends[child + 1] < room_ends[best]) begin
                    best = child + 1;
                end
                if (best == pos) begin
                    break;
                end
                tmp             = room_ends[pos];
                room_ends[pos]  = room_ends[best];
                room_ends[best] = tmp;
                pos             = best;
            end
        end
        if (rooms_in_use < CAPACITY) begin
            room_ends[rooms_in_use] = end_at;
            pos = rooms_in_use;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (room_ends[parent] <= room_ends[pos]) begin
                    break;
                end
                tmp               = room_ends[parent];
                room_ends[parent] = room_ends[pos];
                room_ends[pos]    = tmp;
                pos               = parent;
            end
            rooms_in_use++;
        end else begin
            // heap full and nothing freed: the end time is dropped
            res.overflow = 1'b1;
        end
        res.rooms = rooms_in_use[ROOMS_W-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_room_result want;
        if (!i_rst_n) begin
            rooms_in_use = 0;
            rooms_expected.delete();
            pending_count <= 0;
        end else begin
            // compare before predicting: a result never belongs to the same edge's transaction
            if (i_valid) begin
                if (rooms_expected.size() == 0) begin
                    $error("unexpected result: rooms_needed %0d overflow %0b",
                           i_rooms_needed, i_overflow);
                    failures++;
                end else begin
                    want = rooms_expected.pop_front();
                    if (i_rooms_needed !== want.rooms) begin
                        $error("rooms_needed: expected %0d, actual %0d",
                               want.rooms, i_rooms_needed);
                        failures++;
                    end
                    if (i_overflow !== want.overflow) begin
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, i_overflow);
                        failures++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                rooms_expected.push_back(predict_rooms(i_new_set, i_start_time, i_end_time));
            end
            pending_count <= rooms_expected.size();
        end
    end

endmodule

`default_nettype wire

// File: tb/interval_room_allocator_min_heap_core_test.sv
// ----------------------------------------------------------------------------
// interval_room_allocator_min_heap_core_test
// drives interval sets into the room allocator with random gaps: directed
// corner cases, ordered sets, heap-filling sets and noise; a checker beside
// the block predicts every result and the top reports the verdict
// ----------------------------------------------------------------------------
`default_nettype none

module interval_room_allocator_min_heap_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import irah_pkg::*;

    localparam int                CAPACITY        = CAPACITY_DEF;
    localparam int                INTERVAL_TARGET = 1650;
    localparam int                IDLE_LIMIT      = 2000;
    localparam int                SETTLE_CYCLES   = 16;
    localparam bit [TIME_W-1:0]   TIME_MAX        = '1;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               start        = 1'b0;
    logic               busy;
    logic               i_new_set    = 1'b0;
    logic [TIME_W-1:0]  i_start_time = '0;
    logic [TIME_W-1:0]  i_end_time   = '0;
    logic               o_valid;
    logic [ROOMS_W-1:0] o_rooms_needed;
    logic               o_overflow;

    int pending;
    int failures;
    int intervals_sent = 0;
    int idle_cycles    = 0;

    interval_room_allocator_min_heap_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_new_set      (i_new_set),
        .i_start_time   (i_start_time),
        .i_end_time     (i_end_time),
        .o_valid        (o_valid),
        .o_rooms_needed (o_rooms_needed),
        .o_overflow     (o_overflow)
    );

    interval_room_allocator_min_heap_core_checker #(
        .CAPACITY(CAPACITY)
    ) room_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_new_set      (i_new_set),
        .i_start_time   (i_start_time),
        .i_end_time     (i_end_time),
        .i_valid        (o_valid),
        .i_rooms_needed (o_rooms_needed),
        .i_overflow     (o_overflow),
        .o_pending      (pending),
        .o_failures     (failures)
    );

    always #5 i_clk = ~i_clk;

    // watchdog: once idle_cycles reaches IDLE_LIMIT with no transaction on either side, the run ends as failed
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // start stays high across back-to-back transactions, lowered before a gap and in wait_for_results
    task automatic send_interval(input int unsigned gap, input bit fresh,
                                 input bit [TIME_W-1:0] begin_at,
                                 input bit [TIME_W-1:0] end_at);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_new_set    <= fresh;
        i_start_time <= begin_at;
        i_end_time   <= end_at;
        do @(posedge i_clk); while (busy);
        intervals_sent++;
    endtask

    task automatic wait_for_results;
        start <= 1'b0;
        // the pending count is registered in the checker, so it lags the last transaction
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic bit [TIME_W-1:0] clamp_time(input longint value);
        return (value > longint'(TIME_MAX)) ? TIME_MAX : value[TIME_W-1:0];
    endfunction

    initial begin
        int unsigned     set_kind;
        int unsigned     set_len;
        int unsigned     step_max;
        int unsigned     dur_max;
        bit              burst;
        bit [TIME_W-1:0] base;
        bit [TIME_W-1:0] begin_at;
        int              set_index;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty heap, equal start and end, extremes, end before start
        send_interval(0, 1'b1, '0, '0);
        send_interval(0, 1'b0, '0, TIME_MAX);
        send_interval(3, 1'b0, '0, 31'd5);
        send_interval(0, 1'b0, 31'd5, 31'd9);
        send_interval(1, 1'b0, TIME_MAX, TIME_MAX);
        send_interval(0, 1'b0, TIME_MAX, '0);
        send_interval(0, 1'b1, 31'd100, 31'd50);
        // unordered start, below the smallest end
        send_interval(2, 1'b0, 31'd40, 31'd200);
        send_interval(0, 1'b0, 31'd50, 31'd60);
        send_interval(0, 1'b1, TIME_MAX, TIME_MAX);
        send_interval(0, 1'b1, 31'h2AAA_AAAA, 31'h5555_5555);
        send_interval(5, 1'b0, 31'h5555_5555, 31'h2AAA_AAAA);
        send_interval(0, 1'b0, 31'h5555_5555, TIME_MAX);
        send_interval(0, 1'b0, '0, '0);
        wait_for_results();

        // fill the heap to capacity, overflow it, then free and book at full heap
        base = TIME_W'($urandom_range(0, 1000000));
        for (int i = 0; i < CAPACITY + 5; i++) begin
            send_interval($urandom_range(0, 3), i == 0, base,
                          clamp_time(longint'(base) + 1 + $urandom_range(0, 100000)));
        end
        repeat (3) send_interval($urandom_range(0, 17), 1'b0, TIME_MAX, TIME_MAX);
        wait_for_results();

        set_index = 0;
        while (intervals_sent < INTERVAL_TARGET) begin
            set_index++;
            set_kind = $urandom_range(0, 99);
            burst    = ($urandom_range(0, 3) == 0);
            if (set_kind < 5) begin
                // another set that aims to fill the heap, in a burst or with random gaps
                base    = TIME_W'($urandom);
                set_len = CAPACITY + $urandom_range(1, 12);
                for (int i = 0; i < set_len; i++) begin
                    begin_at = (i >= CAPACITY) ? TIME_MAX : base;
                    send_interval(burst ? 0 : $urandom_range(0, 17), i == 0, begin_at,
                                  clamp_time(longint'(base) + $urandom_range(0, 5000)));
                end
            end else if (set_kind < 80) begin
                // ordered set with random content
                set_len = $urandom_range(1, 40);
                case ($urandom_range(0, 3))
                    0: step_max = 0;
                    1: step_max = 3;
                    2: step_max = 100;
                    default: step_max = 100000;
                endcase
                dur_max  = (step_max + 1) * $urandom_range(1, 12);
                base     = ($urandom_range(0, 3) == 0)
                         ? TIME_W'(TIME_MAX - $urandom_range(0, 1000))
                         : TIME_W'($urandom);
                begin_at = base;
                for (int i = 0; i < set_len; i++) begin
                    begin_at = clamp_time(longint'(begin_at) + $urandom_range(0, step_max));
                    send_interval(burst ? 0 : $urandom_range(0, 17), i == 0, begin_at,
                                  TIME_W'(begin_at + $urandom_range(0, dur_max)));
                end
            end else begin
                // noise: unordered starts, random set boundaries
                set_len = $urandom_range(1, 20);
                for (int i = 0; i < set_len; i++) begin
                    send_interval(burst ? 0 : $urandom_range(0, 17), 1'($urandom_range(0, 1)),
                                  TIME_W'($urandom), TIME_W'($urandom));
                end
            end
            if (set_index % 8 == 0) begin
                wait_for_results();
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/irah_pkg.sv
hdl/irah_heap_mem.sv
hdl/interval_room_allocator_min_heap_core.sv
tb/interval_room_allocator_min_heap_core_checker.sv
tb/interval_room_allocator_min_heap_core_test.sv
